[src/lnfr_pkg.sv]
// Shared definitions for the length-or-newline frame receiver.
// Holds the default buffer depth, character codes, register indexes and the
// types that pass between the receive control, the readout and the top level.
package lnfr_pkg;

   localparam int unsigned LNFR_BUF_DEPTH = 64;

   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_OPEN_BYTE       = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FRAME_BYTES = 1'd1;

   localparam logic [7:0] NL_BYTE = 8'h0A;
   localparam logic [7:0] P_BYTE  = 8'h50;

   localparam logic [7:0] OPEN_BYTE_RESET       = 8'h00;
   localparam logic [6:0] MAX_FRAME_BYTES_RESET = 7'd64;

   localparam logic FRAME_KIND_FIXED = 1'b0;
   localparam logic FRAME_KIND_TEXT  = 1'b1;

   typedef enum logic [3:0] {
      RX_IDLE  = 4'b0001,
      RX_LEN   = 4'b0010,
      RX_TEXT  = 4'b0100,
      RX_FIXED = 4'b1000
   } rx_state_type;

   // Request from the receive control to play a completed frame out of the buffer.
   typedef struct packed {
      logic valid;
      logic kind;
   } deliver_type;

endpackage

[src/length_or_newline_frame_receiver.sv]
// Length-or-newline frame receiver: one received byte per transaction in, one
// payload byte per transaction out. A byte is taken every cycle except while a
// frame is played out; the readout walks the buffer memory one entry a cycle
// unless the output stalls, and the input stalls while it runs. Each byte shows
// from the memory's read register. Reset returns to waiting for the start byte
// and restores the register defaults; the buffer itself is not cleared.
module length_or_newline_frame_receiver #(
   parameter int unsigned BUF_DEPTH = lnfr_pkg::LNFR_BUF_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_rx_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_frame_kind,
   output logic [7:0]                         rsp_data_byte,
   output logic [5:0]                         rsp_byte_index,
   output logic                               rsp_last_byte,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lnfr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lnfr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import lnfr_pkg::*;

   localparam int unsigned AW = $clog2(BUF_DEPTH);

   logic [7:0]    open_byte_ff;
   logic [6:0]    max_frame_bytes_ff;
   logic          byte_accept;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   deliver_type   deliver;
   logic [AW-1:0] deliver_last_idx;
   logic          rd_busy;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] out_idx;

   assign csr_ready   = 1'b1;
   assign req_stall   = rd_busy;
   assign byte_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_byte_ff       <= OPEN_BYTE_RESET;
         max_frame_bytes_ff <= MAX_FRAME_BYTES_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_OPEN_BYTE:       open_byte_ff       <= csr_wdata;
            CSR_MAX_FRAME_BYTES: max_frame_bytes_ff <= csr_wdata[6:0];
            default: begin
            end
         endcase
      end
   end

   lnfr_rx #(
      .BUF_DEPTH (BUF_DEPTH),
      .AW        (AW)
   ) u_rx (
      .clock            (clock),
      .reset            (reset),
      .byte_accept      (byte_accept),
      .rx_byte          (req_rx_byte),
      .open_byte        (open_byte_ff),
      .max_frame_bytes  (max_frame_bytes_ff),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .deliver          (deliver),
      .deliver_last_idx (deliver_last_idx)
   );

   lnfr_frame_mem #(
      .DEPTH (BUF_DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rsp_data_byte)
   );

   lnfr_readout #(
      .AW (AW)
   ) u_readout (
      .clock            (clock),
      .reset            (reset),
      .deliver          (deliver),
      .deliver_last_idx (deliver_last_idx),
      .busy             (rd_busy),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .out_valid        (rsp_valid),
      .out_stall        (rsp_stall),
      .out_kind         (rsp_frame_kind),
      .out_idx          (out_idx),
      .out_last         (rsp_last_byte)
   );

   assign rsp_byte_index = 6'(out_idx);

   // The buffer is never written while a frame is being read out of it.
   a_no_write_during_readout: assert property (
      @(posedge clock) disable iff (reset) wr_en |-> !rd_busy
   ) else $error("frame buffer written during readout");

   // A delivery request always starts a readout on the next cycle.
   a_deliver_starts_readout: assert property (
      @(posedge clock) disable iff (reset) deliver.valid |=> rd_busy
   ) else $error("delivery request did not start a readout");

   // Bytes of one frame follow each other with consecutive positions.
   a_bytes_consecutive: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_byte |=>
         rsp_valid && (rsp_byte_index == $past(rsp_byte_index) + 6'd1)
   ) else $error("frame bytes not consecutive");

endmodule

[src/lnfr_frame_mem.sv]
// Frame buffer: one write port and one read port with registered read data.
// The read data register holds its value until the next read enable.
// Depends on nothing but its parameters.
module lnfr_frame_mem #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/lnfr_rx.sv]
// Receive control: start byte, length byte and payload tracking. Writes
// payload bytes into the frame buffer and raises a delivery request when a
// frame completes, a fixed one only if P opens it. Depends on lnfr_pkg.
module lnfr_rx #(
   parameter int unsigned BUF_DEPTH = 64,
   parameter int unsigned AW        = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     byte_accept,
   input  logic [7:0]               rx_byte,
   input  logic [7:0]               open_byte,
   input  logic [6:0]               max_frame_bytes,
   output logic                     wr_en,
   output logic [AW-1:0]            wr_addr,
   output logic [7:0]               wr_data,
   output lnfr_pkg::deliver_type    deliver,
   output logic [AW-1:0]            deliver_last_idx
);

   import lnfr_pkg::*;

   localparam logic [6:0] DEPTH_LIM = 7'(BUF_DEPTH);

   rx_state_type  state_ff, state_in;
   logic [AW-1:0] wr_idx_ff, wr_idx_in;
   logic [AW-1:0] exp_len_ff, exp_len_in;
   logic          first_p_ff, first_p_in;

   logic [6:0]    eff_lim;
   logic [7:0]    lim8;
   logic [7:0]    count8;
   logic          is_p;

   always_comb begin
      eff_lim = (max_frame_bytes > DEPTH_LIM) ? DEPTH_LIM : max_frame_bytes;
      lim8    = {1'b0, eff_lim};
      count8  = 8'(wr_idx_ff) + 8'd1;
      // The first payload byte decides delivery of a fixed frame.
      is_p    = (wr_idx_ff == '0) ? (rx_byte == P_BYTE) : first_p_ff;
   end

   always_comb begin
      state_in      = state_ff;
      wr_idx_in     = wr_idx_ff;
      exp_len_in    = exp_len_ff;
      first_p_in    = first_p_ff;
      wr_en         = 1'b0;
      deliver.valid = 1'b0;
      deliver.kind  = FRAME_KIND_FIXED;
      if (byte_accept) begin
         case (state_ff)
            RX_IDLE: begin
               if (rx_byte == open_byte) begin
                  state_in = RX_LEN;
               end
            end
            RX_LEN: begin
               wr_idx_in = '0;
               if (rx_byte >= lim8) begin
                  state_in = RX_IDLE;
               end else if (rx_byte == 8'd0) begin
                  state_in = RX_TEXT;
               end else begin
                  exp_len_in = rx_byte[AW-1:0];
                  state_in   = RX_FIXED;
               end
            end
            RX_TEXT: begin
               wr_en = 1'b1;
               if (rx_byte == NL_BYTE) begin
                  state_in  = RX_IDLE;
                  wr_idx_in = '0;
                  if (count8 < lim8) begin
                     deliver.valid = 1'b1;
                     deliver.kind  = FRAME_KIND_TEXT;
                  end
               end else if (count8 >= lim8) begin
                  state_in  = RX_IDLE;
                  wr_idx_in = '0;
               end else begin
                  wr_idx_in = wr_idx_ff + 1'b1;
               end
            end
            RX_FIXED: begin
               wr_en      = 1'b1;
               first_p_in = is_p;
               if (count8 >= 8'(exp_len_ff)) begin
                  state_in      = RX_IDLE;
                  wr_idx_in     = '0;
                  deliver.valid = is_p;
                  deliver.kind  = FRAME_KIND_FIXED;
               end else begin
                  wr_idx_in = wr_idx_ff + 1'b1;
               end
            end
            default: begin
               state_in  = RX_IDLE;
               wr_idx_in = '0;
            end
         endcase
      end
   end

   assign wr_addr          = wr_idx_ff;
   assign wr_data          = rx_byte;
   assign deliver_last_idx = wr_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= RX_IDLE;
         wr_idx_ff  <= '0;
         exp_len_ff <= '0;
         first_p_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wr_idx_ff  <= wr_idx_in;
         exp_len_ff <= exp_len_in;
         first_p_ff <= first_p_in;
      end
   end

endmodule

[src/lnfr_readout.sv]
// Frame readout: walks the frame buffer from entry zero to the last entry and
// presents one byte per transaction, with the memory's read register as the
// output stage. Depends on lnfr_pkg.
module lnfr_readout #(
   parameter int unsigned AW = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lnfr_pkg::deliver_type deliver,
   input  logic [AW-1:0]         deliver_last_idx,
   output logic                  busy,
   output logic                  rd_en,
   output logic [AW-1:0]         rd_addr,
   output logic                  out_valid,
   input  logic                  out_stall,
   output logic                  out_kind,
   output logic [AW-1:0]         out_idx,
   output logic                  out_last
);

   import lnfr_pkg::*;

   logic          active_ff, active_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic [AW-1:0] last_idx_ff, last_idx_in;
   logic          kind_ff, kind_in;
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_kind_ff, s1_kind_in;
   logic [AW-1:0] s1_idx_ff, s1_idx_in;
   logic          s1_last_ff, s1_last_in;
   logic          issue;

   // A read may be issued when the output stage is empty or is being taken.
   assign issue = active_ff && (!s1_valid_ff || !out_stall);

   always_comb begin
      active_in   = active_ff;
      rd_idx_in   = rd_idx_ff;
      last_idx_in = last_idx_ff;
      kind_in     = kind_ff;
      s1_kind_in  = s1_kind_ff;
      s1_idx_in   = s1_idx_ff;
      s1_last_in  = s1_last_ff;
      s1_valid_in = s1_valid_ff && out_stall;
      if (deliver.valid) begin
         active_in   = 1'b1;
         rd_idx_in   = '0;
         last_idx_in = deliver_last_idx;
         kind_in     = deliver.kind;
      end else if (issue) begin
         s1_valid_in = 1'b1;
         s1_kind_in  = kind_ff;
         s1_idx_in   = rd_idx_ff;
         s1_last_in  = (rd_idx_ff == last_idx_ff);
         if (rd_idx_ff == last_idx_ff) begin
            active_in = 1'b0;
         end else begin
            rd_idx_in = rd_idx_ff + 1'b1;
         end
      end
   end

   assign busy      = active_ff;
   assign rd_en     = issue;
   assign rd_addr   = rd_idx_ff;
   assign out_valid = s1_valid_ff;
   assign out_kind  = s1_kind_ff;
   assign out_idx   = s1_idx_ff;
   assign out_last  = s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         active_ff   <= active_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      last_idx_ff <= last_idx_in;
      kind_ff     <= kind_in;
      s1_kind_ff  <= s1_kind_in;
      s1_idx_ff   <= s1_idx_in;
      s1_last_ff  <= s1_last_in;
   end

endmodule
